FILE: sv/stse_pkg.sv
// Shared types and constants of the sorted table search engine.
package stse_pkg;

  localparam int TableDepth = 64;
  localparam int IdxBits    = 6;
  localparam int LenBits    = 7;
  localparam int ValBits    = 32;
  localparam int CntBits    = 7;

  typedef enum logic [1:0] {
    MethLinear = 2'd0,
    MethBinary = 2'd1,
    MethJump   = 2'd2,
    MethInterp = 2'd3
  } method_e;

  typedef enum logic [1:0] {
    RegLength = 2'd0,
    RegMethod = 2'd1,
    RegStep   = 2'd2
  } reg_e;

  typedef enum logic [4:0] {
    StIdle,
    StStart,
    StRead,
    StWait,
    StLinear,
    StBinary,
    StPrepBin,
    StJumpBlk,
    StJumpNext,
    StJumpScan,
    StJumpCmp,
    StInterpLo,
    StInterpHi,
    StInterpDiv,
    StInterpPos,
    StInterpChk,
    StDone,
    StOut
  } state_e;

  // Request to the divider and its reply.
  typedef struct packed {
    logic        start;
    logic [38:0] num;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic [38:0] quot;
  } div_rsp_t;

endpackage

FILE: sv/stse_div.sv
// Restoring divider, one quotient bit per cycle, for the interpolation probe.
module stse_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stse_pkg::div_req_t req_i,
  output stse_pkg::div_rsp_t rsp_o
);

  logic [38:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [32:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [33:0] trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quot_q[38]} - {1'b0, den_q};
    if (req_i.start) begin
      quot_d = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 6'd39;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[33]) begin
        rem_d  = trial[32:0];
        quot_d = {quot_q[37:0], 1'b1};
      end else begin
        rem_d  = {rem_q[31:0], quot_q[38]};
        quot_d = {quot_q[37:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quot = quot_q;

endmodule

FILE: sv/sorted_table_search_engine.sv
// Top level: config registers, value table, search sequencer and divider.
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_ready  | op, entry_index, entry_value, search_key
//  out     | output    | out_valid/out_ready| found, found_index, comparison_count
//  apb     | input     | psel/penable       | table_length, search_method, jump_step
// A write word is stored when it is accepted. A search issues each table read
// through the read and wait states before it compares; jump checks block
// boundaries and then scans entries, and interpolation probes via the serial divider.
// Reset clears control and config; table contents are undefined until written.
// The input is not ready while a search runs or a result waits to be taken.
module sorted_table_search_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [5:0]  entry_index_i,
  input  logic signed [31:0] entry_value_i,
  input  logic signed [31:0] search_key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [5:0]  found_index_o,
  output logic [6:0]  comparison_count_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IB = stse_pkg::IdxBits;
  localparam int LB = stse_pkg::LenBits;
  localparam logic signed [LB:0] SOne = (LB+1)'(1);

  logic [LB-1:0] len_q, step_q;
  logic [1:0]    meth_q;
  logic [1:0]    reg_sel;
  logic          cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LB'(1);
      meth_q <= stse_pkg::MethLinear;
      step_q <= LB'(1);
    end else if (cfg_wr) begin
      case (reg_sel)
        stse_pkg::RegLength: len_q  <= pwdata[LB-1:0];
        stse_pkg::RegMethod: meth_q <= pwdata[1:0];
        stse_pkg::RegStep:   step_q <= pwdata[LB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      stse_pkg::RegLength: prdata = {25'd0, len_q};
      stse_pkg::RegMethod: prdata = {30'd0, meth_q};
      stse_pkg::RegStep:   prdata = {25'd0, step_q};
      default:             prdata = '0;
    endcase
  end

  // Table memory, separate write and read ports, registered read.
  logic signed [31:0] mem [stse_pkg::TableDepth];
  logic [IB-1:0]      raddr;
  logic signed [31:0] rdata_q;
  logic               in_acc, wr_en;

  assign in_acc = in_valid_i && in_ready_o;
  assign wr_en  = in_acc && !op_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[entry_index_i] <= entry_value_i;
    rdata_q <= mem[raddr];
  end

  stse_pkg::state_e st_q, st_d, ret_q, ret_d;
  logic signed [31:0] key_q, key_d, vlo_q, vlo_d;
  logic [LB-1:0] n_q, n_d;
  logic signed [LB:0] lo_q, lo_d, hi_q, hi_d, pos_q, pos_d;
  logic [LB:0]   bnd_q, bnd_d;   // jump block end (step), up to 190
  logic [LB-1:0] prev_q, prev_d, stp_q, stp_d;
  logic [7:0]    cnt_q, cnt_d;
  logic          fnd_q, fnd_d;
  logic [IB-1:0] fidx_q, fidx_d;
  logic [LB:0]   jend;
  logic signed [LB:0] mid;
  logic signed [32:0] diff_key, diff_den;
  logic [38:0]   prod;

  stse_pkg::div_req_t dreq;
  stse_pkg::div_rsp_t drsp;

  function automatic logic [LB-1:0] jend_init(logic [LB-1:0] s, logic [LB-1:0] n);
    jend_init = (s < n) ? s : n;
  endfunction

  stse_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (dreq),
    .rsp_o (drsp)
  );

  assign jend     = (bnd_q < {1'b0, n_q}) ? bnd_q : {1'b0, n_q};
  assign mid      = lo_q + ((hi_q - lo_q) >>> 1);
  assign diff_key = 33'(key_q) - 33'(vlo_q);
  assign diff_den = 33'(rdata_q) - 33'(vlo_q);
  assign prod     = 39'(diff_key) * 39'(hi_q - lo_q);

  // Next state and datapath.
  always_comb begin
    st_d   = st_q;
    ret_d  = ret_q;
    key_d  = key_q;
    vlo_d  = vlo_q;
    n_d    = n_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    pos_d  = pos_q;
    bnd_d  = bnd_q;
    prev_d = prev_q;
    stp_d  = stp_q;
    cnt_d  = cnt_q;
    fnd_d  = fnd_q;
    fidx_d = fidx_q;
    raddr  = pos_q[IB-1:0];
    dreq.start = 1'b0;
    dreq.num   = prod;
    dreq.den   = diff_den;
    case (st_q)
      stse_pkg::StIdle: begin
        if (in_acc && op_i) begin
          key_d = search_key_i;
          n_d   = (len_q > LB'(stse_pkg::TableDepth)) ? LB'(stse_pkg::TableDepth) : len_q;
          cnt_d = '0;
          fnd_d = 1'b0;
          fidx_d = '0;
          stp_d = (step_q == '0) ? LB'(1) : step_q;
          st_d  = stse_pkg::StStart;
        end
      end
      stse_pkg::StStart: begin
        lo_d = '0;
        hi_d = (LB+1)'(n_q) - SOne;
        prev_d = '0;
        bnd_d = {1'b0, stp_q};
        if (n_q == '0) st_d = stse_pkg::StDone;
        else begin
          case (meth_q)
            stse_pkg::MethLinear: begin
              pos_d = '0; ret_d = stse_pkg::StLinear; st_d = stse_pkg::StRead;
            end
            stse_pkg::MethBinary: begin
              st_d = stse_pkg::StBinary;
            end
            stse_pkg::MethJump: begin
              st_d = stse_pkg::StJumpBlk;
            end
            default: begin
              pos_d = '0; ret_d = stse_pkg::StInterpLo; st_d = stse_pkg::StRead;
            end
          endcase
          if (meth_q == stse_pkg::MethBinary) begin
            pos_d = (hi_d >>> 1); ret_d = stse_pkg::StBinary; st_d = stse_pkg::StRead;
          end
          if (meth_q == stse_pkg::MethJump) begin
            pos_d = (LB+1)'(jend_init(stp_q, n_q)) - SOne;
            ret_d = stse_pkg::StJumpBlk; st_d = stse_pkg::StRead;
          end
        end
      end
      stse_pkg::StRead: st_d = stse_pkg::StWait;
      stse_pkg::StWait: st_d = ret_q;
      stse_pkg::StLinear: begin
        cnt_d = cnt_q + 8'd1;
        if (rdata_q == key_q) begin
          fnd_d = 1'b1; fidx_d = pos_q[IB-1:0]; st_d = stse_pkg::StDone;
        end else if (pos_q + SOne >= (LB+1)'(n_q)) st_d = stse_pkg::StDone;
        else begin
          pos_d = pos_q + SOne; st_d = stse_pkg::StRead;
        end
      end
      stse_pkg::StBinary: begin
        cnt_d = cnt_q + 8'd1;
        if (rdata_q == key_q) begin
          fnd_d = 1'b1; fidx_d = pos_q[IB-1:0]; st_d = stse_pkg::StDone;
        end else begin
          if (rdata_q < key_q) lo_d = pos_q + SOne;
          else hi_d = pos_q - SOne;
          st_d = stse_pkg::StPrepBin;
        end
      end
      stse_pkg::StPrepBin: begin
        if (lo_q > hi_q) st_d = stse_pkg::StDone;
        else begin
          pos_d = mid; st_d = stse_pkg::StRead;
        end
      end
      stse_pkg::StJumpBlk: begin
        if (!(rdata_q < key_q)) begin
          pos_d = (LB+1)'(prev_q); st_d = stse_pkg::StJumpScan;
        end else begin
          cnt_d  = cnt_q + 8'd1;
          prev_d = bnd_q[LB-1:0];
          if (bnd_q >= {1'b0, n_q}) st_d = stse_pkg::StDone;
          else begin
            bnd_d = bnd_q + {1'b0, stp_q};
            st_d  = stse_pkg::StJumpNext;
          end
        end
      end
      stse_pkg::StJumpNext: begin
        pos_d = (LB+1)'(jend) - SOne; ret_d = stse_pkg::StJumpBlk; st_d = stse_pkg::StRead;
      end
      stse_pkg::StJumpScan: begin
        if (pos_q >= (LB+1)'(jend)) st_d = stse_pkg::StDone;
        else begin
          ret_d = stse_pkg::StJumpCmp; st_d = stse_pkg::StRead;
        end
      end
      stse_pkg::StJumpCmp: begin
        cnt_d = cnt_q + 8'd1;
        if (rdata_q == key_q) begin
          fnd_d = 1'b1; fidx_d = pos_q[IB-1:0]; st_d = stse_pkg::StDone;
        end else begin
          pos_d = pos_q + SOne; st_d = stse_pkg::StJumpScan;
        end
      end
      stse_pkg::StInterpLo: begin
        // rdata holds table[lo]
        vlo_d = rdata_q;
        if (key_q < rdata_q) st_d = stse_pkg::StDone;
        else begin
          pos_d = hi_q; ret_d = stse_pkg::StInterpHi; st_d = stse_pkg::StRead;
        end
      end
      stse_pkg::StInterpHi: begin
        if (key_q > rdata_q) st_d = stse_pkg::StDone;
        else begin
          cnt_d = cnt_q + 8'd1;
          if (lo_q == hi_q) begin
            fnd_d = (vlo_q == key_q); fidx_d = lo_q[IB-1:0]; st_d = stse_pkg::StDone;
          end else if (rdata_q == vlo_q) begin
            pos_d = lo_q; ret_d = stse_pkg::StInterpPos; st_d = stse_pkg::StRead;
          end else begin
            dreq.start = 1'b1; st_d = stse_pkg::StInterpDiv;
          end
        end
      end
      stse_pkg::StInterpDiv: begin
        if (!drsp.busy) begin
          pos_d = lo_q + (LB+1)'(drsp.quot[LB-1:0]);
          ret_d = stse_pkg::StInterpPos; st_d = stse_pkg::StRead;
        end
      end
      stse_pkg::StInterpPos: begin
        if (rdata_q == key_q) begin
          fnd_d = 1'b1; fidx_d = pos_q[IB-1:0]; st_d = stse_pkg::StDone;
        end else begin
          if (rdata_q < key_q) lo_d = pos_q + SOne;
          else hi_d = pos_q - SOne;
          st_d = stse_pkg::StInterpChk;
        end
      end
      stse_pkg::StInterpChk: begin
        if (lo_q > hi_q) st_d = stse_pkg::StDone;
        else begin
          pos_d = lo_q; ret_d = stse_pkg::StInterpLo; st_d = stse_pkg::StRead;
        end
      end
      stse_pkg::StDone: st_d = stse_pkg::StOut;
      stse_pkg::StOut: if (out_ready_i) st_d = stse_pkg::StIdle;
      default: st_d = stse_pkg::StIdle;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready_o  = (st_q == stse_pkg::StIdle);
    out_valid_o = (st_q == stse_pkg::StOut);
  end

  assign found_o            = fnd_q;
  assign found_index_o      = fnd_q ? fidx_q : '0;
  assign comparison_count_o = (cnt_q > 8'd127) ? 7'd127 : cnt_q[6:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= stse_pkg::StIdle;
      ret_q <= stse_pkg::StIdle;
    end else begin
      st_q  <= st_d;
      ret_q <= ret_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    vlo_q  <= vlo_d;
    n_q    <= n_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    pos_q  <= pos_d;
    bnd_q  <= bnd_d;
    prev_q <= prev_d;
    stp_q  <= stp_d;
    cnt_q  <= cnt_d;
    fnd_q  <= fnd_d;
    fidx_q <= fidx_d;
  end

endmodule
